FILE: hdl/urd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urd_pkg
// Shared types and constants for the unique random draw block.
// ---------------------------------------------------------------------------
package urd_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 9;
  localparam int VAL_W       = 32;
  localparam int RW_W        = 31;
  localparam int STEP_W      = $clog2(RW_W);

  localparam logic KIND_DRAW    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam logic CFG_RANGE_START = 1'b0;
  localparam logic CFG_RANGE_COUNT = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [RW_W-1:0] random_word;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] drawn_value;
    logic                    drawn_ok;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [RW_W-1:0]  dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: hdl/urd_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urd_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module urd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/urd_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urd_divider
// Restoring serial remainder unit, one dividend bit per cycle.
// ---------------------------------------------------------------------------
module urd_divider
  import urd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [RW_W-1:0]   dvd_q;
  logic [CNT_W-1:0]  dsr_q;
  logic [CNT_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;
  logic              run_q;
  logic              done_q;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic [CNT_W-1:0]  rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[RW_W-1]};
    diff  = trial - {1'b0, dsr_q};
    rem_d = (trial >= {1'b0, dsr_q}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q  <= 1'b1;
        step_q <= STEP_W'(RW_W - 1);
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[RW_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[IDX_W-1:0];

endmodule

FILE: hdl/unique_random_draw_int_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unique_random_draw_int_top
// Draws a configured range of integers in random order, no repeat per round.
// ---------------------------------------------------------------------------
// A draw item runs the serial remainder of the 31-bit random word by the
// number of undrawn entries, then the swap on the table memory, which reads
// one entry a cycle, in ST_RD_LAST, ST_RD_PICK, ST_WR_PICK and ST_WR_LAST,
// which registers the result. A draw on an empty or unloaded table answers
// the next cycle. A restart item fills the table entries in order in ST_FILL.
// busy is high throughout; results appear for one cycle on res_valid_o and
// are not held, so the receiver must take them as they come.
module unique_random_draw_int_top
  import urd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         item_i,
  output logic        res_valid_o,
  output out_t        res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_DIV,
    ST_RD_LAST,
    ST_RD_PICK,
    ST_WR_PICK,
    ST_WR_LAST
  } state_e;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_e           state_q;
  logic [VAL_W-1:0] range_start_q;
  logic [CNT_W-1:0] range_count_q;
  logic [CNT_W-1:0] loaded_q;
  logic [CNT_W-1:0] drawn_q;
  logic             table_loaded_q;
  logic [CNT_W-1:0] fill_q;
  logic [IDX_W-1:0] last_q;
  logic [IDX_W-1:0] pick_q;
  logic [VAL_W-1:0] tmp_q;
  logic [VAL_W-1:0] pick_val_q;
  logic             res_valid_q;
  out_t             res_q;

  logic             accept;
  logic [CNT_W-1:0] eff_drawn;
  logic [CNT_W-1:0] remain;
  logic [CNT_W-1:0] fill_nxt;
  logic [CNT_W-1:0] sat_count;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    eff_drawn = (drawn_q >= loaded_q) ? '0 : drawn_q;
    remain    = loaded_q - eff_drawn;
    fill_nxt  = fill_q + 1'b1;
    sat_count = (range_count_q > DEPTH_CNT) ? DEPTH_CNT : range_count_q;

    div_req.start    = accept && (item_i.kind == KIND_DRAW) && table_loaded_q
                       && (loaded_q != '0);
    div_req.dividend = item_i.random_word;
    div_req.divisor  = remain;

    ram_we    = 1'b0;
    ram_waddr = fill_q[IDX_W-1:0];
    ram_wdata = range_start_q + VAL_W'(fill_q);
    ram_raddr = last_q;
    case (state_q)
      ST_FILL: begin
        ram_we = 1'b1;
      end
      ST_RD_PICK: begin
        ram_raddr = pick_q;
      end
      ST_WR_PICK: begin
        ram_we    = 1'b1;
        ram_waddr = pick_q;
        ram_wdata = tmp_q;
      end
      ST_WR_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = last_q;
        ram_wdata = pick_val_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= '0;
      range_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RANGE_START: range_start_q <= cfg_data_i;
        CFG_RANGE_COUNT: range_count_q <= cfg_data_i[CNT_W-1:0];
        default:         range_start_q <= range_start_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      loaded_q       <= '0;
      drawn_q        <= '0;
      table_loaded_q <= 1'b0;
      fill_q         <= '0;
      last_q         <= '0;
      pick_q         <= '0;
      tmp_q          <= '0;
      pick_val_q     <= '0;
      res_valid_q    <= 1'b0;
      res_q          <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (item_i.kind == KIND_RESTART) begin
              loaded_q       <= sat_count;
              drawn_q        <= '0;
              table_loaded_q <= 1'b1;
              fill_q         <= '0;
              if (sat_count != '0) begin
                state_q <= ST_FILL;
              end
            end else if (div_req.start) begin
              drawn_q <= eff_drawn;
              last_q  <= IDX_W'(remain - 1'b1);
              state_q <= ST_DIV;
            end else begin
              res_valid_q <= 1'b1;
              res_q       <= '0;
            end
          end
        end
        ST_FILL: begin
          fill_q <= fill_nxt;
          if (fill_nxt == loaded_q) begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            pick_q  <= div_rsp.rem;
            state_q <= ST_RD_LAST;
          end
        end
        ST_RD_LAST: begin
          state_q <= ST_RD_PICK;
        end
        ST_RD_PICK: begin
          tmp_q   <= ram_rdata;
          state_q <= ST_WR_PICK;
        end
        ST_WR_PICK: begin
          pick_val_q <= ram_rdata;
          state_q    <= ST_WR_LAST;
        end
        ST_WR_LAST: begin
          drawn_q           <= drawn_q + 1'b1;
          res_valid_q       <= 1'b1;
          res_q.drawn_value <= pick_val_q;
          res_q.drawn_ok    <= 1'b1;
          state_q           <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  urd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  urd_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: hdl/urd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urd_checker
// Port-level checks on the unique random draw block, bound to the top level.
// ---------------------------------------------------------------------------
module urd_checker
  import urd_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  item_i,
  input logic res_valid_o,
  input out_t res_o
);

  // restart items give no result
  a_restart_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.kind == KIND_RESTART |=> !res_valid_o)
    else $error("result after restart item");

  // a draw either answers at once or starts work
  a_draw_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.kind == KIND_DRAW |=> res_valid_o || busy)
    else $error("draw item neither answered nor started");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.drawn_ok |-> res_o.drawn_value == '0)
    else $error("nonzero value on failed draw");

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result while busy");

endmodule

bind unique_random_draw_int_top urd_checker u_urd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .item_i      (item_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
